// ----- rtl/core/sau_pkg.sv -----
package sau_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_MOD  = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_DIVZERO   = 2'd3;

  typedef struct packed {
    logic        [2:0]  op;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic        [6:0]  depth;
    logic        [1:0]  status;
  } out_word_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_WB
  } state_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_PUSH,
    CMD_POP
  } cmd_t;

  typedef enum logic [1:0] {
    SH_HOLD,
    SH_DOWN,
    SH_UP
  } shift_t;

endpackage

// ----- rtl/core/sau_cell.sv -----
// One stack entry; takes the entry above on a push, the entry below on a pop.
module sau_cell (
  input  logic            clk,
  input  sau_pkg::shift_t shift,
  input  logic [31:0]     from_above,
  input  logic [31:0]     from_below,
  output logic [31:0]     val
);

  logic [31:0] val_r;
  logic [31:0] val_nxt;

  always_comb begin
    case (shift)
      sau_pkg::SH_DOWN: val_nxt = from_above;
      sau_pkg::SH_UP:   val_nxt = from_below;
      sau_pkg::SH_HOLD: val_nxt = val_r;
      default:          val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// ----- rtl/core/sau_divider.sv -----
// Signed radix-2 restoring divider, one quotient bit per cycle on magnitudes.
module sau_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);

  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] den_r, den_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        neg_q_r, neg_q_nxt;
  logic        neg_r_r, neg_r_nxt;
  logic [32:0] shifted;
  logic [32:0] diff;

  always_comb begin
    shifted   = {rem_r, quo_r[31]};
    diff      = shifted - {1'b0, den_r};
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    den_nxt   = den_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    neg_q_nxt = neg_q_r;
    neg_r_nxt = neg_r_r;
    if (start) begin
      rem_nxt   = 32'd0;
      quo_nxt   = dividend[31] ? (32'd0 - dividend) : dividend;
      den_nxt   = divisor[31] ? (32'd0 - divisor) : divisor;
      cnt_nxt   = 5'd31;
      busy_nxt  = 1'b1;
      neg_q_nxt = dividend[31] ^ divisor[31];
      neg_r_nxt = dividend[31];
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted[31:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    den_r   <= den_nxt;
    cnt_r   <= cnt_nxt;
    neg_q_r <= neg_q_nxt;
    neg_r_r <= neg_r_nxt;
  end

  assign done      = done_r;
  assign quotient  = neg_q_r ? (32'd0 - quo_r) : quo_r;
  assign remainder = neg_r_r ? (32'd0 - rem_r) : rem_r;

endmodule

// ----- rtl/core/stack_arithmetic_unit.sv -----
// Push, add, subtract, multiply and rejected words go from decode straight to
// the write-back state, which registers the result word when output is free;
// divide and modulo first pass through the state of the radix-2 divider loop.
// A new word is accepted only in the idle state, after the last one's write-back.
// Reset clears the depth count and the control; stack entries stay undefined
// until pushed, so no clearing pass is run.
module stack_arithmetic_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sau_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output sau_pkg::out_word_t out_word
);

  localparam int LAST = sau_pkg::STACK_DEPTH - 1;

  // Control registers
  sau_pkg::state_t              state_r, state_nxt;
  logic [sau_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // Payload registers
  sau_pkg::cmd_t                cmd_r, cmd_nxt;
  logic [1:0]                   status_r, status_nxt;
  logic [2:0]                   op_r, op_nxt;
  logic [31:0]                  res_r, res_nxt;
  sau_pkg::out_word_t           out_word_r, out_word_nxt;

  // Decode of the incoming word
  logic                         accept;
  logic                         wb_fire;
  logic                         div_start;
  logic                         dec_is_div;
  sau_pkg::cmd_t                dec_cmd;
  logic [1:0]                   dec_status;
  logic [31:0]                  dec_res;

  // Stack chain
  logic [31:0]                  cell_val [sau_pkg::STACK_DEPTH];
  sau_pkg::shift_t              shift;
  logic [31:0]                  top_val;
  logic [31:0]                  next_val;

  // Divider
  logic                         div_done;
  logic [31:0]                  div_quo;
  logic [31:0]                  div_rem;

  assign top_val  = cell_val[0];
  assign next_val = cell_val[1];

  assign accept  = in_valid && (state_r == sau_pkg::S_IDLE);
  assign wb_fire = (state_r == sau_pkg::S_WB) && (!out_valid_r || !out_stall);

  // Decide what the word does to the stack; only sampled on accept.
  always_comb begin
    dec_cmd    = sau_pkg::CMD_NONE;
    dec_status = sau_pkg::ST_OK;
    dec_res    = 32'd0;
    dec_is_div = 1'b0;
    if (in_word.op == sau_pkg::OP_PUSH) begin
      if (count_r >= sau_pkg::CNT_W'(sau_pkg::STACK_DEPTH)) begin
        dec_status = sau_pkg::ST_OVERFLOW;
      end else begin
        dec_cmd = sau_pkg::CMD_PUSH;
        dec_res = in_word.value;
      end
    end else if (in_word.op <= sau_pkg::OP_MOD) begin
      if (count_r < sau_pkg::CNT_W'(2)) begin
        dec_status = sau_pkg::ST_UNDERFLOW;
      end else begin
        case (in_word.op)
          sau_pkg::OP_ADD: begin
            dec_cmd = sau_pkg::CMD_POP;
            dec_res = next_val + top_val;
          end
          sau_pkg::OP_SUB: begin
            dec_cmd = sau_pkg::CMD_POP;
            dec_res = top_val - next_val;
          end
          sau_pkg::OP_MUL: begin
            dec_cmd = sau_pkg::CMD_POP;
            dec_res = next_val * top_val;
          end
          default: begin
            // divide and modulo: zero divisor leaves the stack alone
            if (top_val == 32'd0) begin
              dec_status = sau_pkg::ST_DIVZERO;
            end else begin
              dec_cmd    = sau_pkg::CMD_POP;
              dec_is_div = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sau_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = dec_is_div ? sau_pkg::S_DIV : sau_pkg::S_WB;
        end
      end
      sau_pkg::S_DIV: begin
        if (div_done) begin
          state_nxt = sau_pkg::S_WB;
        end
      end
      sau_pkg::S_WB: begin
        if (wb_fire) begin
          state_nxt = sau_pkg::S_IDLE;
        end
      end
      default: state_nxt = sau_pkg::S_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    cmd_nxt       = cmd_r;
    status_nxt    = status_r;
    op_nxt        = op_r;
    res_nxt       = res_r;
    count_nxt     = count_r;
    out_word_nxt  = out_word_r;
    div_start     = 1'b0;
    shift         = sau_pkg::SH_HOLD;
    // drop the held result once taken, hold it while stalled
    out_valid_nxt = wb_fire || (out_valid_r && out_stall);
    case (state_r)
      sau_pkg::S_IDLE: begin
        if (accept) begin
          cmd_nxt    = dec_cmd;
          status_nxt = dec_status;
          op_nxt     = in_word.op;
          res_nxt    = dec_res;
          div_start  = dec_is_div;
        end
      end
      sau_pkg::S_DIV: begin
        if (div_done) begin
          res_nxt = (op_r == sau_pkg::OP_DIV) ? div_quo : div_rem;
        end
      end
      sau_pkg::S_WB: begin
        if (wb_fire) begin
          out_word_nxt.status = status_r;
          case (cmd_r)
            sau_pkg::CMD_PUSH: begin
              shift                  = sau_pkg::SH_DOWN;
              count_nxt              = count_r + sau_pkg::CNT_W'(1);
              out_word_nxt.top_value = res_r;
            end
            sau_pkg::CMD_POP: begin
              shift                  = sau_pkg::SH_UP;
              count_nxt              = count_r - sau_pkg::CNT_W'(1);
              out_word_nxt.top_value = res_r;
            end
            default: begin
              out_word_nxt.top_value = (count_r == '0) ? 32'd0 : top_val;
            end
          endcase
          out_word_nxt.depth = 7'(count_nxt);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sau_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    status_r   <= status_nxt;
    op_r       <= op_nxt;
    res_r      <= res_nxt;
    out_word_r <= out_word_nxt;
  end

  // Row of cells: cell 0 is the top. A push shifts the row down and loads
  // the new value into cell 0; an operation shifts the row up from cell 1
  // and loads the result into cell 0. The bottom cell refills from itself.
  for (genvar i = 0; i < sau_pkg::STACK_DEPTH; i++) begin : g_cell
    logic [31:0] above;
    logic [31:0] below;
    if (i == 0) begin : g_top
      assign above = res_r;
      assign below = res_r;
    end else if (i == LAST) begin : g_bottom
      assign above = cell_val[i-1];
      assign below = cell_val[i];
    end else begin : g_mid
      assign above = cell_val[i-1];
      assign below = cell_val[i+1];
    end
    sau_cell u_cell (
      .clk        (clk),
      .shift      (shift),
      .from_above (above),
      .from_below (below),
      .val        (cell_val[i])
    );
  end

  sau_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (next_val),
    .divisor   (top_val),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign in_stall  = (state_r != sau_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
